/* rtl/pcw_pkg.sv */
// ----------------------------------------------------------------------------
// PNG chunk walker package
// Shared payload types, command and phase codes, chunk type words and small
// lookup functions for the byte-serial PNG chunk walker.
// ----------------------------------------------------------------------------
`default_nettype none

package pcw_pkg;

    // Default palette store size in bytes (three bytes per entry).
    localparam int PALETTE_BYTES_DEF = 768;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reciprocal of three for lengths below 1024: floor(x / 3) = (x * 683) >> 11.
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_IN_W  = 10;
    localparam int DIV3_PRD_W = 20;

    // Input action codes.
    localparam logic [1:0] ACT_DATA    = 2'd0;
    localparam logic [1:0] ACT_RESTART = 2'd1;
    localparam logic [1:0] ACT_EOS     = 2'd2;

    // Result kinds.
    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // Report status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ST_NOT_IHDR  = 3'd2;
    localparam logic [2:0] ST_NO_IDAT   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    // Color codes.
    localparam logic [2:0] COLOR_GREY       = 3'd0;
    localparam logic [2:0] COLOR_TRUE       = 3'd1;
    localparam logic [2:0] COLOR_INDEXED    = 3'd2;
    localparam logic [2:0] COLOR_GREY_ALPHA = 3'd3;
    localparam logic [2:0] COLOR_TRUE_ALPHA = 3'd4;
    localparam logic [2:0] COLOR_UNKNOWN    = 3'd5;

    // Chunk type words, big-endian ASCII.
    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // Classified command carried from the front to the back.
    typedef enum logic [1:0] {
        OP_DATA,
        OP_RESTART,
        OP_EOS,
        OP_NOP
    } pcw_op_t;

    // Parse phase of the chunk walker.
    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_BODY,
        PH_CRC
    } pcw_phase_t;

    // Progress through the chunk sequence.
    typedef enum logic [1:0] {
        WS_HEADER,
        WS_NO_DATA,
        WS_HAS_DATA
    } pcw_stage_t;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } pcw_in_t;

    // Output transaction payload.
    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [31:0] width;
        logic [31:0] height;
        logic [7:0]  bit_depth;
        logic [2:0]  color_code;
        logic [31:0] data_offset;
        logic [31:0] data_size;
        logic [8:0]  palette_count;
        logic [9:0]  palette_index;
        logic [7:0]  palette_value;
    } pcw_out_t;

    // Queue entry.
    typedef struct packed {
        pcw_op_t    op;
        logic [7:0] data_byte;
    } pcw_cmd_t;

    // Head of the queue as seen by the back.
    typedef struct packed {
        logic     valid;
        pcw_cmd_t cmd;
    } pcw_head_t;

    // Expected signature byte at a given position.
    function automatic logic [7:0] sig_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Map a header color type to its code.
    function automatic logic [2:0] map_color(input logic [7:0] t);
        logic [2:0] c;
        case (t)
            8'd0:    c = COLOR_GREY;
            8'd2:    c = COLOR_TRUE;
            8'd3:    c = COLOR_INDEXED;
            8'd4:    c = COLOR_GREY_ALPHA;
            8'd6:    c = COLOR_TRUE_ALPHA;
            default: c = COLOR_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/pcw_front.sv */
// ----------------------------------------------------------------------------
// PNG chunk walker front
// Accepts input transactions, classifies the action into a command and
// queues it for the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module pcw_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire pcw_pkg::pcw_in_t in_data,
    output pcw_pkg::pcw_head_t   head,
    input  wire logic            pop
);

    pcw_pkg::pcw_cmd_t                 queue_mem [pcw_pkg::QUEUE_DEPTH];
    logic [pcw_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [pcw_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [pcw_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [pcw_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [pcw_pkg::QCNT_W-1:0]        count_reg;
    logic [pcw_pkg::QCNT_W-1:0]        count_next;
    pcw_pkg::pcw_cmd_t                 cmd_in;
    logic                              push;
    logic                              do_pop;

    // Classify the incoming action.
    always_comb
    begin
        cmd_in.data_byte = in_data.data_byte;
        case (in_data.action)
            pcw_pkg::ACT_DATA:    cmd_in.op = pcw_pkg::OP_DATA;
            pcw_pkg::ACT_RESTART: cmd_in.op = pcw_pkg::OP_RESTART;
            pcw_pkg::ACT_EOS:     cmd_in.op = pcw_pkg::OP_EOS;
            default:              cmd_in.op = pcw_pkg::OP_NOP;
        endcase
    end

    // Queue handshake.
    assign in_ready   = (count_reg != pcw_pkg::QCNT_W'(pcw_pkg::QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = queue_mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    // The fill count never passes the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pcw_pkg::QCNT_W'(pcw_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    // Pointers meet whenever the queue is empty or full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == pcw_pkg::QCNT_W'(pcw_pkg::QUEUE_DEPTH))
        |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

    // A transaction pushed into an empty queue shows at the head next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        push && count_reg == '0 |=> head.valid)
        else $error("queue head lost a pushed command");

endmodule

`default_nettype wire

/* rtl/pcw_back.sv */
// ----------------------------------------------------------------------------
// PNG chunk walker back
// Executes one queued command per cycle while its output register is empty
// or being drained: walks the signature and chunks, captures header and image
// data fields, emits palette bytes and reports.
`default_nettype none

module pcw_back #(
    parameter int PALETTE_BYTES = pcw_pkg::PALETTE_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pcw_pkg::pcw_head_t head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pcw_pkg::pcw_out_t       out_data
);

    localparam int PAL_CAP   = PALETTE_BYTES / 3;
    localparam int CAP_BYTES = PAL_CAP * 3;

    // Parser state.
    pcw_pkg::pcw_phase_t phase_reg, phase_next;
    pcw_pkg::pcw_stage_t stage_reg, stage_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [31:0]         pos_reg, pos_next;
    logic [31:0]         len_reg, len_next;
    logic [31:0]         type_reg, type_next;
    logic [31:0]         rem_reg, rem_next;
    logic                sig_ok_reg, sig_ok_next;
    logic [31:0]         width_reg, width_next;
    logic [31:0]         height_reg, height_next;
    logic [7:0]          depth_reg, depth_next;
    logic [2:0]          color_reg, color_next;
    logic [31:0]         doff_reg, doff_next;
    logic [31:0]         dsize_reg, dsize_next;
    logic [8:0]          entries_reg, entries_next;
    logic [9:0]          pidx_reg, pidx_next;
    logic                finished_reg, finished_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    pcw_pkg::pcw_out_t   out_data_reg;

    // Decode and datapath helpers.
    logic                go;
    logic                run_data;
    logic [7:0]          b;
    logic                field_last;
    logic                sig_good;
    logic [31:0]         type_word;
    logic [31:0]         body_idx;
    logic [31:0]         rem_dec;
    logic [pcw_pkg::DIV3_PRD_W-1:0] div3_prod;
    logic [8:0]          pal_entries;
    logic                res_valid;
    logic                rep_fire;
    logic                pal_fire;
    logic [2:0]          rep_status;
    pcw_pkg::pcw_out_t   res;

    // A command executes whenever the output register can take a result.
    assign go        = head.valid && (!out_valid_reg || out_ready);
    assign pop       = go;
    assign b         = head.cmd.data_byte;
    assign run_data  = go && !finished_reg && (head.cmd.op == pcw_pkg::OP_DATA);
    assign field_last = (cnt_reg == 3'd3);
    assign sig_good  = sig_ok_reg && (b == pcw_pkg::sig_byte(cnt_reg));
    assign type_word = {type_reg[23:0], b};
    assign body_idx  = len_reg - rem_reg;
    assign rem_dec   = rem_reg - 32'd1;

    // Palette entry count: lengths below the cap fit the narrow reciprocal.
    assign div3_prod = pcw_pkg::DIV3_PRD_W'(len_reg[pcw_pkg::DIV3_IN_W-1:0])
                     * pcw_pkg::DIV3_PRD_W'(pcw_pkg::DIV3_MUL);
    assign pal_entries = (len_reg >= 32'(CAP_BYTES)) ? 9'(PAL_CAP)
                       : div3_prod[pcw_pkg::DIV3_SHIFT +: 9];

    // Next parse phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (go && head.cmd.op == pcw_pkg::OP_RESTART)
        begin
            phase_next = pcw_pkg::PH_SIG;
        end
        else if (run_data)
        begin
            case (phase_reg)
                pcw_pkg::PH_SIG:
                begin
                    if (cnt_reg == 3'd7 && sig_good)
                    begin
                        phase_next = pcw_pkg::PH_LEN;
                    end
                end
                pcw_pkg::PH_LEN:
                begin
                    if (field_last)
                    begin
                        phase_next = pcw_pkg::PH_TYPE;
                    end
                end
                pcw_pkg::PH_TYPE:
                begin
                    if (field_last)
                    begin
                        phase_next = (len_reg != '0) ? pcw_pkg::PH_BODY : pcw_pkg::PH_CRC;
                    end
                end
                pcw_pkg::PH_BODY:
                begin
                    if (rem_dec == '0)
                    begin
                        phase_next = pcw_pkg::PH_CRC;
                    end
                end
                pcw_pkg::PH_CRC:
                begin
                    if (field_last)
                    begin
                        phase_next = pcw_pkg::PH_LEN;
                    end
                end
                default:
                begin
                    phase_next = pcw_pkg::PH_SIG;
                end
            endcase
        end
    end

    // Field capture, counters and result selection.
    always_comb
    begin
        stage_next    = stage_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        type_next     = type_reg;
        rem_next      = rem_reg;
        sig_ok_next   = sig_ok_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        depth_next    = depth_reg;
        color_next    = color_reg;
        doff_next     = doff_reg;
        dsize_next    = dsize_reg;
        entries_next  = entries_reg;
        pidx_next     = pidx_reg;
        finished_next = finished_reg;
        rep_fire      = 1'b0;
        pal_fire      = 1'b0;
        rep_status    = pcw_pkg::ST_OK;

        if (go && head.cmd.op == pcw_pkg::OP_RESTART)
        begin
            stage_next    = pcw_pkg::WS_HEADER;
            cnt_next      = '0;
            pos_next      = '0;
            len_next      = '0;
            type_next     = '0;
            rem_next      = '0;
            sig_ok_next   = 1'b1;
            width_next    = '0;
            height_next   = '0;
            depth_next    = '0;
            color_next    = pcw_pkg::COLOR_UNKNOWN;
            doff_next     = '0;
            dsize_next    = '0;
            entries_next  = '0;
            pidx_next     = '0;
            finished_next = 1'b0;
        end
        else if (go && !finished_reg && head.cmd.op == pcw_pkg::OP_EOS)
        begin
            rep_fire   = 1'b1;
            rep_status = pcw_pkg::ST_TRUNCATED;
        end
        else if (run_data)
        begin
            pos_next = pos_reg + 32'd1;
            case (phase_reg)
                pcw_pkg::PH_SIG:
                begin
                    sig_ok_next = sig_good;
                    cnt_next    = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7 && !sig_good)
                    begin
                        rep_fire   = 1'b1;
                        rep_status = pcw_pkg::ST_BAD_SIG;
                    end
                end
                pcw_pkg::PH_LEN:
                begin
                    len_next = {len_reg[23:0], b};
                    cnt_next = field_last ? 3'd0 : cnt_reg + 3'd1;
                end
                pcw_pkg::PH_TYPE:
                begin
                    type_next = type_word;
                    cnt_next  = field_last ? 3'd0 : cnt_reg + 3'd1;
                    if (field_last)
                    begin
                        rem_next = len_reg;
                        if (stage_reg == pcw_pkg::WS_HEADER)
                        begin
                            // The first chunk must be the header.
                            if (type_word != pcw_pkg::TYPE_IHDR)
                            begin
                                rep_fire   = 1'b1;
                                rep_status = pcw_pkg::ST_NOT_IHDR;
                            end
                            else if (len_reg == '0)
                            begin
                                stage_next = pcw_pkg::WS_NO_DATA;
                            end
                        end
                        else if (type_word == pcw_pkg::TYPE_IDAT)
                        begin
                            doff_next  = pos_next;
                            dsize_next = len_reg;
                            stage_next = pcw_pkg::WS_HAS_DATA;
                        end
                        else if (type_word == pcw_pkg::TYPE_PLTE)
                        begin
                            entries_next = pal_entries;
                            pidx_next    = '0;
                        end
                        else if (type_word == pcw_pkg::TYPE_IEND)
                        begin
                            rep_fire   = 1'b1;
                            rep_status = (stage_reg == pcw_pkg::WS_HAS_DATA)
                                       ? pcw_pkg::ST_OK : pcw_pkg::ST_NO_IDAT;
                        end
                    end
                end
                pcw_pkg::PH_BODY:
                begin
                    rem_next = rem_dec;
                    if (stage_reg == pcw_pkg::WS_HEADER)
                    begin
                        // Header body: width, height, depth, color type.
                        if (body_idx < 32'd4)
                        begin
                            width_next = {width_reg[23:0], b};
                        end
                        else if (body_idx < 32'd8)
                        begin
                            height_next = {height_reg[23:0], b};
                        end
                        else if (body_idx == 32'd8)
                        begin
                            depth_next = b;
                        end
                        else if (body_idx == 32'd9)
                        begin
                            color_next = pcw_pkg::map_color(b);
                        end
                        if (rem_dec == '0)
                        begin
                            stage_next = pcw_pkg::WS_NO_DATA;
                        end
                    end
                    else if (type_reg == pcw_pkg::TYPE_PLTE
                             && pidx_reg < 10'(PALETTE_BYTES))
                    begin
                        pal_fire  = 1'b1;
                        pidx_next = pidx_reg + 10'd1;
                    end
                end
                pcw_pkg::PH_CRC:
                begin
                    cnt_next = field_last ? 3'd0 : cnt_reg + 3'd1;
                end
                default:
                begin
                    cnt_next = '0;
                end
            endcase
        end

        if (rep_fire)
        begin
            finished_next = 1'b1;
        end
    end

    // Result payload.
    assign res_valid = rep_fire || pal_fire;
    always_comb
    begin
        res               = '0;
        res.palette_count = entries_reg;
        if (rep_fire)
        begin
            res.kind        = pcw_pkg::KIND_REPORT;
            res.status      = rep_status;
            res.width       = width_reg;
            res.height      = height_reg;
            res.bit_depth   = depth_reg;
            res.color_code  = color_reg;
            res.data_offset = doff_reg;
            res.data_size   = dsize_reg;
        end
        else
        begin
            res.kind          = pcw_pkg::KIND_PALETTE;
            res.palette_index = pidx_reg;
            res.palette_value = b;
        end
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pcw_pkg::PH_SIG;
            stage_reg     <= pcw_pkg::WS_HEADER;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            len_reg       <= '0;
            type_reg      <= '0;
            rem_reg       <= '0;
            sig_ok_reg    <= 1'b1;
            width_reg     <= '0;
            height_reg    <= '0;
            depth_reg     <= '0;
            color_reg     <= pcw_pkg::COLOR_UNKNOWN;
            doff_reg      <= '0;
            dsize_reg     <= '0;
            entries_reg   <= '0;
            pidx_reg      <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            stage_reg     <= stage_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            type_reg      <= type_next;
            rem_reg       <= rem_next;
            sig_ok_reg    <= sig_ok_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            depth_reg     <= depth_next;
            color_reg     <= color_next;
            doff_reg      <= doff_next;
            dsize_reg     <= dsize_next;
            entries_reg   <= entries_next;
            pidx_reg      <= pidx_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    // No result is produced once a report has gone out.
    assert property (@(posedge clk) disable iff (!rst_n)
        go && res_valid |-> !finished_reg)
        else $error("result after final report");

    // Palette results stay inside the palette store.
    assert property (@(posedge clk) disable iff (!rst_n)
        go && pal_fire |-> pidx_reg < 10'(PALETTE_BYTES))
        else $error("palette index beyond store");

    // Outside the signature, field counters never pass four bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != pcw_pkg::PH_SIG |-> cnt_reg < 3'd4)
        else $error("field byte count out of range");

    // A chunk body in progress always has bytes left.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == pcw_pkg::PH_BODY |-> rem_reg != '0)
        else $error("body phase with no bytes remaining");

endmodule

`default_nettype wire

/* rtl/png_chunk_walker_unit.sv */
// ----------------------------------------------------------------------------
// PNG chunk walker
// Byte-serial PNG chunk walker: checks the signature, walks chunks, captures
// header and image data fields, emits palette bytes and a final report.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in      | input     | in_valid/in_ready   | pcw_in_t  (action, data_byte)
//  out     | output    | out_valid/out_ready | pcw_out_t (palette byte or report)
//
//  One byte per cycle sustained while the output keeps up; results reach the
//  output register through the four-entry command queue.
//  The back executes one queued command per cycle while its output
//  register is empty or being drained; the queue absorbs output stalls.
//  Reset is asynchronous and active low; no clearing pass is needed.
//  Input ready drops only when the command queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module png_chunk_walker_unit #(
    parameter int PALETTE_BYTES = pcw_pkg::PALETTE_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pcw_pkg::pcw_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pcw_pkg::pcw_out_t      out_data
);

    pcw_pkg::pcw_head_t head;
    logic               pop;

    // Front: accept and classify, queue commands.
    pcw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .head     (head),
        .pop      (pop)
    );

    // Back: walk the stream and produce results.
    pcw_back #(
        .PALETTE_BYTES (PALETTE_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* dv/png_chunk_walker_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk walker checker
// Watches both channels of the chunk walker. Every accepted input transaction
// runs through a behavioral copy of the walker, which queues the palette bytes
// and parse reports it should produce. Every accepted output transaction is
// compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module png_chunk_walker_check #(
    parameter int PAL_BYTES = pcw_pkg::PALETTE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  pcw_pkg::pcw_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  pcw_pkg::pcw_out_t out_data,
    output int unsigned       mismatches,
    output int unsigned       outstanding
);

    // The eight signature bytes, first byte in the top lane.
    localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;

    // Walker state as seen from outside.
    pcw_pkg::pcw_phase_t phase;
    int unsigned         field_cnt;
    logic [31:0]         byte_pos;
    logic [31:0]         chunk_len;
    logic [31:0]         chunk_type;
    logic [31:0]         body_left;
    pcw_pkg::pcw_stage_t stage;
    bit                  magic_ok;
    logic [31:0]         img_width;
    logic [31:0]         img_height;
    logic [7:0]          img_depth;
    logic [2:0]          img_color;
    logic [31:0]         idat_offset;
    logic [31:0]         idat_size;
    logic [8:0]          pal_entries;
    logic [9:0]          pal_next;
    bit                  parse_done;

    // Palette bytes and reports still owed by the block, oldest first.
    pcw_pkg::pcw_out_t predicted_outs[$];
    int unsigned       bad_results = 0;
    int unsigned       waiting     = 0;

    assign mismatches  = bad_results;
    assign outstanding = waiting;

    // Return the walker to its power-up state.
    task automatic clear_walker();
        phase       = pcw_pkg::PH_SIG;
        field_cnt   = 0;
        byte_pos    = '0;
        chunk_len   = '0;
        chunk_type  = '0;
        body_left   = '0;
        stage       = pcw_pkg::WS_HEADER;
        magic_ok    = 1'b1;
        img_width   = '0;
        img_height  = '0;
        img_depth   = '0;
        img_color   = pcw_pkg::COLOR_UNKNOWN;
        idat_offset = '0;
        idat_size   = '0;
        pal_entries = '0;
        pal_next    = '0;
        parse_done  = 1'b0;
    endtask

    // PNG color type to color code.
    function automatic logic [2:0] color_code_of(input logic [7:0] ctype);
        case (ctype)
            8'd0:    return pcw_pkg::COLOR_GREY;
            8'd2:    return pcw_pkg::COLOR_TRUE;
            8'd3:    return pcw_pkg::COLOR_INDEXED;
            8'd4:    return pcw_pkg::COLOR_GREY_ALPHA;
            8'd6:    return pcw_pkg::COLOR_TRUE_ALPHA;
            default: return pcw_pkg::COLOR_UNKNOWN;
        endcase
    endfunction

    // Queue a final report; nothing but a restart is honored afterwards.
    task automatic post_report(input logic [2:0] st);
        pcw_pkg::pcw_out_t r;
        r               = '0;
        r.kind          = pcw_pkg::KIND_REPORT;
        r.status        = st;
        r.width         = img_width;
        r.height        = img_height;
        r.bit_depth     = img_depth;
        r.color_code    = img_color;
        r.data_offset   = idat_offset;
        r.data_size     = idat_size;
        r.palette_count = pal_entries;
        predicted_outs.push_back(r);
        parse_done = 1'b1;
    endtask

    // The fourth type byte has arrived: classify the chunk.
    task automatic finish_type();
        logic [31:0] groups;
        body_left = chunk_len;
        phase     = (chunk_len != 0) ? pcw_pkg::PH_BODY : pcw_pkg::PH_CRC;
        if (stage == pcw_pkg::WS_HEADER)
        begin
            if (chunk_type != pcw_pkg::TYPE_IHDR)
                post_report(pcw_pkg::ST_NOT_IHDR);
            else if (chunk_len == 0)
                stage = pcw_pkg::WS_NO_DATA;
        end
        else if (chunk_type == pcw_pkg::TYPE_IDAT)
        begin
            // Position already points at the first body byte.
            idat_offset = byte_pos;
            idat_size   = chunk_len;
            stage       = pcw_pkg::WS_HAS_DATA;
        end
        else if (chunk_type == pcw_pkg::TYPE_PLTE)
        begin
            groups      = chunk_len / 3;
            pal_entries = (groups > PAL_BYTES / 3) ? 9'(PAL_BYTES / 3) : groups[8:0];
            pal_next    = '0;
        end
        else if (chunk_type == pcw_pkg::TYPE_IEND)
        begin
            post_report((stage == pcw_pkg::WS_HAS_DATA) ? pcw_pkg::ST_OK
                                                        : pcw_pkg::ST_NO_IDAT);
        end
    endtask

    // One body byte: header capture or palette output.
    task automatic take_body(input logic [7:0] b);
        logic [31:0]       idx;
        pcw_pkg::pcw_out_t r;
        idx       = chunk_len - body_left;
        body_left = body_left - 32'd1;
        if (stage == pcw_pkg::WS_HEADER)
        begin
            if (idx < 4)
                img_width = {img_width[23:0], b};
            else if (idx < 8)
                img_height = {img_height[23:0], b};
            else if (idx == 8)
                img_depth = b;
            else if (idx == 9)
                img_color = color_code_of(b);
            if (body_left == 0)
                stage = pcw_pkg::WS_NO_DATA;
        end
        else if (chunk_type == pcw_pkg::TYPE_PLTE && pal_next < PAL_BYTES)
        begin
            r               = '0;
            r.kind          = pcw_pkg::KIND_PALETTE;
            r.palette_count = pal_entries;
            r.palette_index = pal_next;
            r.palette_value = b;
            predicted_outs.push_back(r);
            pal_next = pal_next + 10'd1;
        end
        if (body_left == 0)
            phase = pcw_pkg::PH_CRC;
    endtask

    // Advance the walker by one accepted input transaction.
    task automatic walk_item(input pcw_pkg::pcw_in_t it);
        logic [7:0] b;
        b = it.data_byte;
        if (it.action == pcw_pkg::ACT_RESTART)
        begin
            clear_walker();
        end
        else if (!parse_done)
        begin
            if (it.action == pcw_pkg::ACT_EOS)
            begin
                post_report(pcw_pkg::ST_TRUNCATED);
            end
            else if (it.action == pcw_pkg::ACT_DATA)
            begin
                byte_pos = byte_pos + 32'd1;
                case (phase)
                    pcw_pkg::PH_SIG:
                    begin
                        if (b != PNG_MAGIC[63 - 8 * field_cnt -: 8])
                            magic_ok = 1'b0;
                        field_cnt++;
                        if (field_cnt >= 8)
                        begin
                            field_cnt = 0;
                            if (!magic_ok)
                                post_report(pcw_pkg::ST_BAD_SIG);
                            else
                                phase = pcw_pkg::PH_LEN;
                        end
                    end
                    pcw_pkg::PH_LEN:
                    begin
                        chunk_len = {chunk_len[23:0], b};
                        field_cnt++;
                        if (field_cnt >= 4)
                        begin
                            field_cnt = 0;
                            phase     = pcw_pkg::PH_TYPE;
                        end
                    end
                    pcw_pkg::PH_TYPE:
                    begin
                        chunk_type = {chunk_type[23:0], b};
                        field_cnt++;
                        if (field_cnt >= 4)
                        begin
                            field_cnt = 0;
                            finish_type();
                        end
                    end
                    pcw_pkg::PH_BODY:
                    begin
                        take_body(b);
                    end
                    default:
                    begin
                        // CRC bytes are skipped.
                        field_cnt++;
                        if (field_cnt >= 4)
                        begin
                            field_cnt = 0;
                            phase     = pcw_pkg::PH_LEN;
                        end
                    end
                endcase
            end
        end
    endtask

    // Compare one field; the heading line goes out with the first bad field.
    task automatic diff_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got, input bit show, inout bit bad);
        if (want !== got)
        begin
            if (show && !bad)
                $display("[%0t] output transaction mismatch", $time);
            if (show)
                $display("  %s: expected 0x%0h, actual 0x%0h", fname, want, got);
            bad = 1'b1;
        end
    endtask

    // Check an output transaction against its prediction.
    task automatic compare_result(input pcw_pkg::pcw_out_t want,
                                  input pcw_pkg::pcw_out_t got);
        bit show;
        bit bad;
        show = (bad_results < 10);
        bad  = 1'b0;
        diff_field("kind", 32'(want.kind), 32'(got.kind), show, bad);
        diff_field("status", 32'(want.status), 32'(got.status), show, bad);
        diff_field("width", want.width, got.width, show, bad);
        diff_field("height", want.height, got.height, show, bad);
        diff_field("bit_depth", 32'(want.bit_depth), 32'(got.bit_depth), show, bad);
        diff_field("color_code", 32'(want.color_code), 32'(got.color_code), show, bad);
        diff_field("data_offset", want.data_offset, got.data_offset, show, bad);
        diff_field("data_size", want.data_size, got.data_size, show, bad);
        diff_field("palette_count", 32'(want.palette_count), 32'(got.palette_count),
                   show, bad);
        diff_field("palette_index", 32'(want.palette_index), 32'(got.palette_index),
                   show, bad);
        diff_field("palette_value", 32'(want.palette_value), 32'(got.palette_value),
                   show, bad);
        if (bad)
            bad_results++;
    endtask

    // Sample both channels at the clock edge, predict first, then compare.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_walker();
            predicted_outs.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                walk_item(in_data);
            if (out_valid && out_ready)
            begin
                if (predicted_outs.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("[%0t] unexpected output transaction: kind %0d status %0d",
                                 $time, out_data.kind, out_data.status);
                end
                else
                begin
                    compare_result(predicted_outs.pop_front(), out_data);
                end
            end
        end
        waiting = predicted_outs.size();
    end

endmodule

/* dv/png_chunk_walker_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk walker testbench
// Feeds the walker a short directed byte sequence, then a long run of
// generated PNG files: mostly well-formed chunk walks with random content,
// mixed with damaged signatures, wrong first chunks, missing image data,
// oversized palettes, truncation and stray commands. Both channels stall at
// random in the first two of three idling phases. The checker does all the predicting.
// ----------------------------------------------------------------------------
module png_chunk_walker_unit_test;

    // Action value the walker does not use.
    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam logic [63:0] PNG_MAGIC  = 64'h8950_4E47_0D0A_1A0A;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    pcw_pkg::pcw_in_t  in_data;
    logic              out_valid;
    logic              out_ready;
    pcw_pkg::pcw_out_t out_data;
    int unsigned       mismatches;
    int unsigned       outstanding;

    int                send_idle;
    int                recv_idle;
    int unsigned       items_sent;
    pcw_pkg::pcw_in_t  file_q[$];
    logic [7:0]        body_bytes[$];

    png_chunk_walker_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    png_chunk_walker_check walk_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Free-running clock, 4 ns period.
    always #2 clk = ~clk;

    // Receiver stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drive one input transaction, with random gaps in front of it.
    task automatic push_item(input pcw_pkg::pcw_in_t it);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic flush_queue();
        while (file_q.size() != 0)
            push_item(file_q.pop_front());
    endtask

    task automatic add_item(input logic [1:0] act, input logic [7:0] b);
        pcw_pkg::pcw_in_t it;
        it.action    = act;
        it.data_byte = b;
        file_q.push_back(it);
    endtask

    // A file byte, now and then preceded by a command the walker ignores.
    task automatic add_data(input logic [7:0] b);
        if ($urandom_range(0, 99) < 2)
            add_item(ACT_UNUSED, 8'($urandom));
        add_item(pcw_pkg::ACT_DATA, b);
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            add_data(w[8 * i +: 8]);
    endtask

    // Length, type, the bytes in body_bytes, and a random CRC.
    task automatic add_chunk(input logic [31:0] len, input logic [31:0] tag);
        add_word(len);
        add_word(tag);
        foreach (body_bytes[i])
            add_data(body_bytes[i]);
        add_word($urandom);
    endtask

    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Build one restart-prefixed PNG file into file_q.
    task automatic build_file(input bit big_palette);
        logic [7:0]  hdr [18];
        logic [31:0] tag;
        logic [31:0] len;
        int          hdr_len;
        int          n_mid;
        int          kind;
        int          bad_pos;
        int          keep;
        int          roll;
        bit          want_idat;
        bit          have_idat;
        bit          open_ended;
        logic [7:0]  b;

        add_item(pcw_pkg::ACT_RESTART, 8'($urandom));

        // Signature, with one byte damaged now and then.
        bad_pos = ($urandom_range(0, 99) < 6) ? $urandom_range(0, 7) : 8;
        for (int i = 0; i < 8; i++)
        begin
            b = PNG_MAGIC[63 - 8 * i -: 8];
            if (i == bad_pos)
                b = b ^ 8'($urandom_range(1, 255));
            add_data(b);
        end

        // Header chunk: usually full size, sometimes short, long or mistyped.
        {hdr[0], hdr[1], hdr[2], hdr[3]} = any_word();
        {hdr[4], hdr[5], hdr[6], hdr[7]} = any_word();
        case ($urandom_range(0, 5))
            0:       hdr[8] = 8'd1;
            1:       hdr[8] = 8'd2;
            2:       hdr[8] = 8'd4;
            3:       hdr[8] = 8'd8;
            4:       hdr[8] = 8'd16;
            default: hdr[8] = 8'($urandom);
        endcase
        // Legal PNG color types are 0, 2, 3, 4 and 6.
        case ($urandom_range(0, 6))
            0:       hdr[9] = 8'd0;
            1:       hdr[9] = 8'd2;
            2:       hdr[9] = 8'd3;
            3:       hdr[9] = 8'd4;
            4:       hdr[9] = 8'd6;
            default: hdr[9] = 8'($urandom);
        endcase
        for (int i = 10; i < 18; i++)
            hdr[i] = 8'($urandom);
        hdr_len = ($urandom_range(0, 99) < 75) ? 13 : $urandom_range(0, 18);
        tag     = pcw_pkg::TYPE_IHDR;
        if ($urandom_range(0, 99) < 6)
        begin
            case ($urandom_range(0, 3))
                0:       tag = pcw_pkg::TYPE_IDAT;
                1:       tag = pcw_pkg::TYPE_IEND;
                2:       tag = pcw_pkg::TYPE_PLTE;
                default: tag = $urandom;
            endcase
        end
        body_bytes.delete();
        for (int i = 0; i < hdr_len; i++)
            body_bytes.push_back(hdr[i]);
        add_chunk(hdr_len, tag);

        // Middle chunks.
        want_idat  = ($urandom_range(0, 99) >= 12);
        have_idat  = 1'b0;
        open_ended = 1'b0;
        n_mid      = $urandom_range(big_palette ? 1 : 0, 4);
        for (int i = 0; i < n_mid && !open_ended; i++)
        begin
            kind = (big_palette && i == 0) ? 0 : $urandom_range(0, 9);
            if (kind <= 2)
            begin
                tag = pcw_pkg::TYPE_PLTE;
                if (big_palette && i == 0)
                    len = 32'd771;
                else
                    len = 3 * $urandom_range(0, 12)
                          + (($urandom_range(0, 99) < 20) ? $urandom_range(1, 2) : 0);
            end
            else if (kind <= 5)
            begin
                tag = want_idat ? pcw_pkg::TYPE_IDAT : $urandom;
                len = $urandom_range(0, 24);
                have_idat = have_idat | want_idat;
            end
            else if (kind == 6)
            begin
                tag = pcw_pkg::TYPE_IHDR;
                len = $urandom_range(0, 16);
            end
            else if (kind == 7)
            begin
                // Huge chunk that the file never finishes.
                open_ended = 1'b1;
                len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : {1'b1, 31'($urandom)};
                tag = $urandom_range(0, 1) ? pcw_pkg::TYPE_PLTE : $urandom;
            end
            else
            begin
                tag = $urandom;
                len = $urandom_range(0, 12);
            end
            if (open_ended)
            begin
                add_word(len);
                add_word(tag);
                repeat ($urandom_range(1, 8))
                    add_data(8'($urandom));
            end
            else
            begin
                body_bytes.delete();
                repeat (len)
                    body_bytes.push_back(8'($urandom));
                add_chunk(len, tag);
            end
        end

        if (!open_ended)
        begin
            body_bytes.delete();
            if (want_idat && !have_idat)
            begin
                repeat ($urandom_range(0, 8))
                    body_bytes.push_back(8'($urandom));
                add_chunk(body_bytes.size(), pcw_pkg::TYPE_IDAT);
                body_bytes.delete();
            end
            // End chunk; a nonzero length is ignored after the report.
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    body_bytes.push_back(8'($urandom));
            add_chunk(body_bytes.size(), pcw_pkg::TYPE_IEND);
        end

        // Ending: cut short, trailing junk, or clean.
        roll = $urandom_range(0, 99);
        if (open_ended || roll < 12)
        begin
            if (!open_ended)
            begin
                keep = $urandom_range(1, file_q.size() - 1);
                while (file_q.size() > keep)
                    void'(file_q.pop_back());
            end
            if (open_ended || $urandom_range(0, 3) != 0)
                add_item(pcw_pkg::ACT_EOS, 8'($urandom));
        end
        else if (roll < 25)
        begin
            repeat ($urandom_range(1, 4))
                add_data(8'($urandom));
            add_item(pcw_pkg::ACT_EOS, 8'($urandom));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        int spins;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        send_idle  = 13;
        recv_idle  = 79;
        items_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ignored command, truncation at reset, finished state,
        // then a maximum-length header cut off mid-width.
        add_item(ACT_UNUSED, 8'hFF);
        add_item(pcw_pkg::ACT_EOS, 8'h00);
        add_item(pcw_pkg::ACT_EOS, 8'hFF);
        add_item(pcw_pkg::ACT_DATA, 8'h89);
        add_item(pcw_pkg::ACT_RESTART, 8'h00);
        for (int i = 0; i < 8; i++)
            add_item(pcw_pkg::ACT_DATA, PNG_MAGIC[63 - 8 * i -: 8]);
        for (int i = 0; i < 4; i++)
            add_item(pcw_pkg::ACT_DATA, 8'hFF);
        for (int i = 3; i >= 0; i--)
            add_item(pcw_pkg::ACT_DATA, pcw_pkg::TYPE_IHDR[8 * i +: 8]);
        add_item(pcw_pkg::ACT_DATA, 8'hFF);
        add_item(pcw_pkg::ACT_DATA, 8'h00);
        add_item(pcw_pkg::ACT_DATA, 8'h80);
        add_item(pcw_pkg::ACT_EOS, 8'h5A);
        flush_queue();

        // Random files; the first one overflows the palette store.
        build_file(1'b1);
        flush_queue();
        while (items_sent < 750)
        begin
            build_file(1'b0);
            flush_queue();
        end

        send_idle = 79;
        recv_idle = 13;
        while (items_sent < 1150)
        begin
            build_file(1'b0);
            flush_queue();
        end

        send_idle = 0;
        recv_idle = 0;
        while (items_sent < 1500)
        begin
            build_file(1'b0);
            flush_queue();
        end
        in_valid <= 1'b0;

        // Drain, then give stray outputs a chance to show up.
        spins = 0;
        while (outstanding != 0 && spins < 50000)
        begin
            @(negedge clk);
            spins++;
        end
        repeat (20) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/pcw_pkg.sv
rtl/pcw_front.sv
rtl/pcw_back.sv
rtl/png_chunk_walker_unit.sv
dv/png_chunk_walker_check.sv
dv/png_chunk_walker_unit_test.sv
